// ----- hw/rtl/stpp_pkg.sv -----
// package for the shape test pattern pixel generator
// frame geometry, shape and register codes, item types
// no dependencies

package stpp_pkg;

	localparam int FRAME_WIDTH  = 320;
	localparam int FRAME_HEIGHT = 256;

	localparam int DIM       = (FRAME_WIDTH < FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
	localparam int RAD       = DIM / 2;
	localparam int MID       = FRAME_WIDTH / 2;
	localparam int SQ_START  = (FRAME_WIDTH - DIM) / 2;
	localparam int SQ_END    = SQ_START + DIM;
	localparam int RAD_SQ    = RAD * RAD;

	localparam int COORD_W   = 13;
	localparam int MAG_W     = 12;
	localparam int SQ_W      = 2 * MAG_W + 1;
	localparam int CSUM_W    = 20;

	localparam logic [7:0]  LUMA_RESET = 8'd128;
	localparam logic [7:0]  ALPHA      = 8'hff;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic [MAG_W-1:0]          mag_t;
	typedef logic [SQ_W-1:0]           sq_t;
	typedef logic signed [CSUM_W-1:0]  csum_t;

	typedef enum logic [1:0] {
		SHAPE_SQUARE   = 2'd0,
		SHAPE_CIRCLE   = 2'd1,
		SHAPE_TRIANGLE = 2'd2,
		SHAPE_NONE     = 2'd3
	} shape_t;

	typedef enum logic {
		REG_SHAPE_SELECT = 1'b0,
		REG_FILL_LUMA    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [8:0] column;
		logic [7:0] row;
		logic [7:0] chroma_u;
		logic [7:0] chroma_v;
	} pixel_in_t;

	typedef struct packed {
		logic [31:0] pixel_word;
		logic        inside_shape;
	} pixel_out_t;

endpackage

// ----- hw/rtl/shape_test_pattern_pixel.sv -----
// shape test pattern pixel generator, top level
// three-stage pipeline: shape test and yuv to argb fill colour
// depends on stpp_pkg

// Takes one pixel item in every clock cycle (busy stays low) and gives its
// result marked by a one-cycle done strobe. The rate of one item per cycle
// comes from the three-stage pipeline: constant products and offsets,
// then channel sums and squares, then the circle compare, shift and clip.
// The receiver cannot stall the block, so every result must be taken in
// the cycle it is shown. The user must write the shape and luma registers
// via APB only while no items are in flight; the block does not enforce it.

module shape_test_pattern_pixel (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  stpp_pkg::pixel_in_t   pixel_in,
	output logic                  done,
	output stpp_pkg::pixel_out_t  result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [2:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);
	import stpp_pkg::*;

	// configuration registers
	shape_t     shape_q;
	logic [7:0] luma_q;
	reg_idx_t   reg_idx;

	assign reg_idx = reg_idx_t'(paddr[2]);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shape_q <= SHAPE_SQUARE;
			luma_q  <= LUMA_RESET;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_SHAPE_SELECT: shape_q <= shape_t'(pwdata[1:0]);
				REG_FILL_LUMA:    luma_q  <= pwdata[7:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_SHAPE_SELECT: prdata = {30'd0, shape_q};
			REG_FILL_LUMA:    prdata = {24'd0, luma_q};
			default:          prdata = 32'd0;
		endcase
	end

	assign busy = 1'b0;

	// stage 1 logic
	logic        accept;
	coord_t      col_c, row_c, dx_c, dy_c, k_c;
	logic        in_frame, sq_hit, tri_hit, circ_row_ok;
	mag_t        mx_c, my_c;
	csum_t       c_c, d_c, e_c;

	assign accept = start && !busy;

	always_comb begin
		col_c    = coord_t'({1'b0, pixel_in.column});
		row_c    = coord_t'({1'b0, pixel_in.row});
		in_frame = (col_c < coord_t'(FRAME_WIDTH)) && (row_c < coord_t'(FRAME_HEIGHT));
		sq_hit   = (row_c < coord_t'(DIM)) && (col_c >= coord_t'(SQ_START))
			&& (col_c < coord_t'(SQ_END));
		k_c      = (row_c + coord_t'(1)) >>> 1;
		tri_hit  = (row_c < coord_t'(DIM)) && (col_c >= coord_t'(MID) - k_c)
			&& (col_c <= coord_t'(MID) + k_c);
		circ_row_ok = row_c < coord_t'(2 * RAD);
		dx_c     = col_c - coord_t'(MID);
		dy_c     = row_c - coord_t'(RAD);
		mx_c     = (dx_c >= 0) ? mag_t'(dx_c + coord_t'(1)) : mag_t'(-dx_c);
		my_c     = (dy_c >= 0) ? mag_t'(dy_c) : mag_t'(-dy_c);
		c_c      = csum_t'({1'b0, luma_q}) - csum_t'(16);
		d_c      = csum_t'({1'b0, pixel_in.chroma_u}) - csum_t'(128);
		e_c      = csum_t'({1'b0, pixel_in.chroma_v}) - csum_t'(128);
	end

	// stage 1 registers
	logic   v_s1, hit_s1, circ_s1;
	mag_t   mx_s1, my_s1;
	csum_t  yc_s1, re_s1, gd_s1, ge_s1, bd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			circ_s1 <= in_frame && circ_row_ok && (shape_q == SHAPE_CIRCLE);
			case (shape_q)
				SHAPE_SQUARE:   hit_s1 <= in_frame && sq_hit;
				SHAPE_TRIANGLE: hit_s1 <= in_frame && tri_hit;
				default:        hit_s1 <= 1'b0;
			endcase
			mx_s1 <= mx_c;
			my_s1 <= my_c;
			yc_s1 <= c_c * csum_t'(298);
			re_s1 <= e_c * csum_t'(409);
			gd_s1 <= d_c * csum_t'(100);
			ge_s1 <= e_c * csum_t'(208);
			bd_s1 <= d_c * csum_t'(516);
		end
	end

	// stage 2 registers
	logic   v_s2, hit_s2, circ_s2;
	sq_t    sx_s2, sy_s2;
	csum_t  r_s2, g_s2, b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			hit_s2  <= hit_s1;
			circ_s2 <= circ_s1;
			sx_s2   <= sq_t'(mx_s1) * sq_t'(mx_s1);
			sy_s2   <= sq_t'(my_s1) * sq_t'(my_s1);
			r_s2    <= yc_s1 + re_s1 + csum_t'(128);
			g_s2    <= yc_s1 - gd_s1 - ge_s1 + csum_t'(128);
			b_s2    <= yc_s1 + bd_s1 + csum_t'(128);
		end
	end

	// stage 3: circle compare, shift, clip
	function automatic logic [7:0] clip8(input csum_t s);
		csum_t t;
		t = s >>> 8;
		if (t < 0)
			return 8'd0;
		else if (t > csum_t'(255))
			return 8'hff;
		else
			return t[7:0];
	endfunction

	logic inside_c;
	assign inside_c = hit_s2 || (circ_s2 && ((sx_s2 + sy_s2) <= sq_t'(RAD_SQ)));

	logic       v_s3;
	pixel_out_t out_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			out_s3.inside_shape <= inside_c;
			out_s3.pixel_word   <= inside_c
				? {ALPHA, clip8(r_s2), clip8(g_s2), clip8(b_s2)} : 32'd0;
		end
	end

	assign done   = v_s3;
	assign result = out_s3;

endmodule
